// ----- hw/rtl/ccpt_pkg.sv -----
package ccpt_pkg;

	localparam int AXES   = 3;
	localparam int AX_W   = $clog2(AXES);
	localparam int ZAXIS  = 2;
	localparam int PER_W  = 7;
	localparam int POS_W  = 21;
	localparam int VEL_W  = 26;
	localparam int TIME_W = 20;
	localparam int FRAC   = 24;
	localparam int U_W    = FRAC + 1;
	localparam int DIV_W  = 34;
	localparam int DCNT_W = 6;
	localparam int IDX_W  = 2;
	localparam int MAG_W  = 22;

	localparam logic [TIME_W-1:0] TIME_MAX    = '1;
	localparam logic [TIME_W-1:0] DUR_RESET   = 20'd5000;
	localparam logic [TIME_W-1:0] MIN_STOP_MS = 20'd1000;
	localparam logic signed [23:0] POS_LIM    = 24'sd1000000;
	localparam logic [DIV_W-1:0] VEL_LIM      = 34'd33554431;
	localparam logic [DIV_W-1:0] SLOW_UM_S    = 34'd100;
	localparam logic signed [POS_W-1:0] ZMIN_UM = 21'sd15000;
	localparam logic [43:0] RADIUS_SQ         = 44'd731025000000;

	localparam logic [IDX_W-1:0] REG_TARGET_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_TARGET_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_TARGET_Z = 2'd2;
	localparam logic [IDX_W-1:0] REG_DURATION = 2'd3;

endpackage

// ----- hw/rtl/ccpt_div.sv -----
// restoring divider, one quotient bit per cycle
module ccpt_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ccpt_pkg::TIME_W-1:0]      rem_init,
	input  logic [ccpt_pkg::DIV_W-1:0]       num,
	input  logic [ccpt_pkg::DCNT_W-1:0]      steps,
	input  logic [ccpt_pkg::TIME_W-1:0]      divisor,
	output logic                             done,
	output logic [ccpt_pkg::DIV_W-1:0]       quot
);

	logic [ccpt_pkg::TIME_W-1:0] rem_q;
	logic [ccpt_pkg::DIV_W-1:0]  num_q;
	logic [ccpt_pkg::DIV_W-1:0]  quot_q;
	logic [ccpt_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ccpt_pkg::TIME_W:0]   trial;
	logic [ccpt_pkg::TIME_W:0]   diff;
	logic                        ge;

	assign trial = {rem_q, num_q[ccpt_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == ccpt_pkg::DCNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ccpt_pkg::DCNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			num_q  <= num;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[ccpt_pkg::TIME_W-1:0] : trial[ccpt_pkg::TIME_W-1:0];
			num_q  <= {num_q[ccpt_pkg::DIV_W-2:0], 1'b0};
			quot_q <= {quot_q[ccpt_pkg::DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- hw/rtl/cubic_point_to_point_trajectory_top.sv -----
// Each input transaction runs in order: a 25-step time ratio divide, 25-step square and
// cube multiplies, then per axis 22 multiply steps plus 34 divide steps. One item in
// flight: a new tick is taken only in idle, after the last result has gone to the output
// register, which waits while m_tvalid is high and m_tready low. The divider is shared.
// Reset (arst_n, async): idle, elapsed time 0, start point 0, targets 0, duration 5000 ms.
module cubic_point_to_point_trajectory_top (
	input  logic         clk,
	input  logic         arst_n,
	// config write port
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [20:0]  cfg_data,
	// tick in
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,  // period_ms[6:0], current_x, current_y, current_z, pad
	// trajectory out
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, pad
	output logic         m_tlast,  // finished
	output logic         m_tuser   // target_invalid
);

	localparam int A  = ccpt_pkg::AXES;
	localparam int PW = ccpt_pkg::POS_W;
	localparam int VW = ccpt_pkg::VEL_W;
	localparam int TW = ccpt_pkg::TIME_W;
	localparam int UW = ccpt_pkg::U_W;
	localparam int MW = ccpt_pkg::MAG_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIVU_GO, ST_DIVU, ST_SQ, ST_CU, ST_HG,
		ST_AX_LD, ST_AX, ST_AX_END, ST_DIVV, ST_DONE
	} state_t;

	state_t state_q;

	// config and motion state
	logic signed [PW-1:0] target_q [A];
	logic [TW-1:0]        dur_q;
	logic [TW-1:0]        el_q;
	logic signed [PW-1:0] start_q [A];
	logic                 in_motion_q;

	// shared arithmetic
	logic [UW-1:0]        u_q, u2_q, u3_q, h_q, mq_q;
	logic [34:0]          g6_q;
	logic [2*UW-1:0]      acc_q;
	logic [4:0]           cnt_q;
	logic [ccpt_pkg::AX_W-1:0] ax_q;
	logic [MW-1:0]        md_q, mt_q, tabs_q;
	logic                 dneg_q;
	logic [46:0]          accp_q;
	logic [56:0]          accv_q;
	logic [41:0]          accs_q;
	logic [43:0]          sum_q;
	logic                 slow_q;
	logic signed [PW-1:0] pos_q [A];
	logic signed [VW-1:0] vel_q [A];

	// output register
	logic                 m_tvalid_q;
	logic [143:0]         m_tdata_q;
	logic                 m_tlast_q;
	logic                 m_tuser_q;

	// divider hookup
	logic                        div_go_q;
	logic [TW-1:0]               div_rem_q;
	logic [ccpt_pkg::DIV_W-1:0]  div_num_q;
	logic [ccpt_pkg::DCNT_W-1:0] div_steps_q;
	logic                        div_done;
	logic [ccpt_pkg::DIV_W-1:0]  div_quot;

	// clamp a latched start point to the position range
	function automatic logic signed [PW-1:0] sat_pos(logic signed [PW-1:0] p);
		if (p > ccpt_pkg::POS_LIM)
			return PW'(ccpt_pkg::POS_LIM);
		if (p < -ccpt_pkg::POS_LIM)
			return PW'(-ccpt_pkg::POS_LIM);
		return p;
	endfunction

	ccpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.rem_init (div_rem_q),
		.num      (div_num_q),
		.steps    (div_steps_q),
		.divisor  (dur_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	logic          s_acc;
	logic [TW:0]   el_sum;
	logic [TW-1:0] tau;
	logic [UW-1:0] mcand;
	logic [2*UW-1:0] acc_nxt;
	logic [26:0]   h_w;
	logic [UW-1:0] g_w;
	logic [37:0]   g6_w;
	logic signed [MW-1:0] d_w;
	logic signed [MW-1:0] t_w;
	logic [23:0]   rp_w;
	logic signed [23:0] p_w;
	logic [57:0]   nv_w;
	logic [ccpt_pkg::DIV_W-1:0] vq_w;
	logic signed [VW-1:0] v_w;
	logic          last_ax;
	logic          invalid_w;
	logic          fin_w;
	logic          out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign el_sum   = (in_motion_q ? {1'b0, el_q} : '0) + (TW+1)'(s_tdata[6:0]);
	assign tau      = (el_q < dur_q) ? el_q : dur_q;

	// MSB-first shift-add multiply for the square and the cube
	assign mcand   = (state_q == ST_SQ) ? u_q : u2_q;
	assign acc_nxt = {acc_q[2*UW-2:0], 1'b0} + (mq_q[UW-1] ? (2*UW)'(mcand) : '0);

	assign h_w  = 27'(3 * u2_q) - 27'(2 * u3_q);
	assign g_w  = u_q - u2_q;
	// times 6000 = 4096 + 2048 - 128 - 16
	assign g6_w = (38'(g_w) << 12) + (38'(g_w) << 11) - (38'(g_w) << 7) - (38'(g_w) << 4);

	assign d_w = MW'(target_q[ax_q]) - MW'(start_q[ax_q]);
	assign t_w = MW'(target_q[ax_q]);

	// round half away from zero on the position term
	assign rp_w = 24'((accp_q + 47'(1 << 23)) >> ccpt_pkg::FRAC);
	assign p_w  = 24'(start_q[ax_q]) + (dneg_q ? -$signed(rp_w) : $signed(rp_w));
	assign nv_w = (58'(accv_q) + (58'(dur_q) << 23)) >> ccpt_pkg::FRAC;

	assign vq_w = (div_quot > ccpt_pkg::VEL_LIM) ? ccpt_pkg::VEL_LIM : div_quot;
	assign v_w  = dneg_q ? -$signed(VW'(vq_w)) : $signed(VW'(vq_w));

	assign last_ax   = (ax_q == ccpt_pkg::AX_W'(A - 1));
	assign invalid_w = (sum_q > ccpt_pkg::RADIUS_SQ) ||
		(target_q[ccpt_pkg::ZAXIS] < ccpt_pkg::ZMIN_UM);
	assign fin_w     = (el_q >= dur_q) ||
		((invalid_w || slow_q) && (el_q > ccpt_pkg::MIN_STOP_MS));
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < A; i++) begin
				target_q[i] <= '0;
				start_q[i]  <= '0;
			end
			dur_q       <= ccpt_pkg::DUR_RESET;
			el_q        <= '0;
			in_motion_q <= 1'b0;
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			div_go_q    <= 1'b0;
		end else begin
			// divider kicks off for the time ratio and for each axis velocity, unless the duration is zero
			div_go_q <= (dur_q != '0) && ((state_q == ST_DIVU_GO) || (state_q == ST_AX_END));
			if (m_tvalid_q && m_tready && (state_q != ST_DONE))
				m_tvalid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					ccpt_pkg::REG_TARGET_X: target_q[0] <= cfg_data;
					ccpt_pkg::REG_TARGET_Y: target_q[1] <= cfg_data;
					ccpt_pkg::REG_TARGET_Z: target_q[2] <= cfg_data;
					ccpt_pkg::REG_DURATION: dur_q <= cfg_data[TW-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (!in_motion_q) begin
							start_q[0] <= s_tdata[27:7];
							start_q[1] <= s_tdata[48:28];
							start_q[2] <= s_tdata[69:49];
						end
						el_q        <= el_sum[TW] ? ccpt_pkg::TIME_MAX : el_sum[TW-1:0];
						in_motion_q <= 1'b1;
						state_q     <= ST_DIVU_GO;
					end
				end
				ST_DIVU_GO: begin
					acc_q <= '0;
					cnt_q <= 5'(UW);
					if (dur_q == '0) begin
						// zero duration: ratio pinned at one
						u_q     <= UW'(1) << ccpt_pkg::FRAC;
						mq_q    <= UW'(1) << ccpt_pkg::FRAC;
						state_q <= ST_SQ;
					end else begin
						// tau <= T, so the upper quotient bits are zero
						div_rem_q   <= tau >> 1;
						div_num_q   <= {tau[0], 33'b0};
						div_steps_q <= ccpt_pkg::DCNT_W'(UW);
						state_q     <= ST_DIVU;
					end
				end
				ST_DIVU: begin
					if (div_done) begin
						u_q     <= div_quot[UW-1:0];
						mq_q    <= div_quot[UW-1:0];
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (cnt_q == 5'd1) begin
						u2_q    <= acc_nxt[48:24];
						acc_q   <= '0;
						mq_q    <= u_q;
						cnt_q   <= 5'(UW);
						state_q <= ST_CU;
					end else begin
						acc_q <= acc_nxt;
						mq_q  <= mq_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_CU: begin
					acc_q <= acc_nxt;
					mq_q  <= mq_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 5'd1) begin
						u3_q    <= acc_nxt[48:24];
						state_q <= ST_HG;
					end
				end
				ST_HG: begin
					h_q     <= h_w[UW-1:0];
					g6_q    <= g6_w[34:0];
					ax_q    <= '0;
					slow_q  <= 1'b1;
					sum_q   <= '0;
					state_q <= ST_AX_LD;
				end
				ST_AX_LD: begin
					dneg_q  <= d_w[MW-1];
					md_q    <= d_w[MW-1] ? MW'(-d_w) : MW'(d_w);
					tabs_q  <= t_w[MW-1] ? MW'(-t_w) : MW'(t_w);
					mt_q    <= t_w[MW-1] ? MW'(-t_w) : MW'(t_w);
					accp_q  <= '0;
					accv_q  <= '0;
					accs_q  <= '0;
					cnt_q   <= 5'(MW);
					state_q <= ST_AX;
				end
				ST_AX: begin
					// one bit of |d| and |t| per cycle
					accp_q <= {accp_q[45:0], 1'b0} + (md_q[MW-1] ? 47'(h_q) : '0);
					accv_q <= {accv_q[55:0], 1'b0} + (md_q[MW-1] ? 57'(g6_q) : '0);
					accs_q <= {accs_q[40:0], 1'b0} + (mt_q[MW-1] ? 42'(tabs_q) : '0);
					md_q   <= md_q << 1;
					mt_q   <= mt_q << 1;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == 5'd1)
						state_q <= ST_AX_END;
				end
				ST_AX_END: begin
					if (p_w > ccpt_pkg::POS_LIM)
						pos_q[ax_q] <= PW'(ccpt_pkg::POS_LIM);
					else if (p_w < -ccpt_pkg::POS_LIM)
						pos_q[ax_q] <= PW'(-ccpt_pkg::POS_LIM);
					else
						pos_q[ax_q] <= p_w[PW-1:0];
					sum_q <= sum_q + 44'(accs_q);
					if (dur_q == '0) begin
						vel_q[ax_q] <= '0;
						ax_q        <= ax_q + 1'b1;
						state_q     <= last_ax ? ST_DONE : ST_AX_LD;
					end else begin
						div_rem_q   <= '0;
						div_num_q   <= nv_w[ccpt_pkg::DIV_W-1:0];
						div_steps_q <= ccpt_pkg::DCNT_W'(ccpt_pkg::DIV_W);
						state_q     <= ST_DIVV;
					end
				end
				ST_DIVV: begin
					if (div_done) begin
						vel_q[ax_q] <= v_w;
						if (div_quot >= ccpt_pkg::SLOW_UM_S)
							slow_q <= 1'b0;
						ax_q    <= ax_q + 1'b1;
						state_q <= last_ax ? ST_DONE : ST_AX_LD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q  <= 1'b1;
						in_motion_q <= !fin_w;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload; an invalid target holds the start point at rest
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {3'b0,
				invalid_w ? VW'(0) : vel_q[2],
				invalid_w ? VW'(0) : vel_q[1],
				invalid_w ? VW'(0) : vel_q[0],
				invalid_w ? sat_pos(start_q[2]) : pos_q[2],
				invalid_w ? sat_pos(start_q[1]) : pos_q[1],
				invalid_w ? sat_pos(start_q[0]) : pos_q[0]};
			m_tlast_q <= fin_w;
			m_tuser_q <= invalid_w;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule
